// ===== hw/rtl/spc_pkg.sv =====
// shared types, constants and helpers of the servo pulse ramp controller
package spc_pkg;

    localparam int ADDR_W = 4;

    localparam logic [15:0] FULL_WIDTH = 16'h8000;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [7:0]  ALL_CH     = 8'hFF;

    localparam logic [15:0] MIN_COUNT_RST  = 16'd1000;
    localparam logic [15:0] SPAN_COUNT_RST = 16'd1000;
    localparam logic [15:0] RAMP_STEP_RST  = 16'd655;
    localparam logic [15:0] SAFE_WIDTH_RST = 16'd16384;

    localparam logic [1:0] REG_MIN_COUNT  = 2'd0;
    localparam logic [1:0] REG_SPAN_COUNT = 2'd1;
    localparam logic [1:0] REG_RAMP_STEP  = 2'd2;
    localparam logic [1:0] REG_SAFE_WIDTH = 2'd3;

    typedef enum logic [2:0] {
        MODE_SET_NOW  = 3'd0,
        MODE_SET_RAMP = 3'd1,
        MODE_STOP     = 3'd2,
        MODE_RELEASE  = 3'd3,
        MODE_TICK     = 3'd4,
        MODE_READ     = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [15:0] min_count;
        logic [15:0] span_count;
        logic [15:0] ramp_step;
        logic [15:0] safe_width;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic calc;
        logic load_out;
        logic next_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic go_walk;
        logic emit_here;
        logic done;
        logic out_free;
    } t_dp_sts;

    function automatic logic [15:0] sat_width(input logic [15:0] w);
        return (w > FULL_WIDTH) ? FULL_WIDTH : w;
    endfunction

endpackage

// ===== hw/rtl/spc_req_if.sv =====
// request channel: command mode, channel and width
interface spc_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [7:0]  channel;
    logic [15:0] width;

    modport source (output valid, output mode, output channel, output width, input ready);
    modport sink (input valid, input mode, input channel, input width, output ready);
endinterface

// ===== hw/rtl/spc_res_if.sv =====
// result channel: compare updates and read replies
interface spc_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  out_channel;
    logic [15:0] compare_count;
    logic [15:0] current_width;
    logic        read_ok;
    logic        last;

    modport source (output valid, output kind, output out_channel, output compare_count,
                    output current_width, output read_ok, output last, input ready);
    modport sink (input valid, input kind, input out_channel, input compare_count,
                  input current_width, input read_ok, input last, output ready);
endinterface

// ===== hw/rtl/spc_regs.sv =====
// apb configuration registers
module spc_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [spc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output spc_pkg::t_cfg              o_cfg
);
    import spc_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] reg_sel;

    assign reg_sel = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_count  <= MIN_COUNT_RST;
            r_cfg.span_count <= SPAN_COUNT_RST;
            r_cfg.ramp_step  <= RAMP_STEP_RST;
            r_cfg.safe_width <= SAFE_WIDTH_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_MIN_COUNT:  r_cfg.min_count  <= pwdata[15:0];
                REG_SPAN_COUNT: r_cfg.span_count <= pwdata[15:0];
                REG_RAMP_STEP:  r_cfg.ramp_step  <= pwdata[15:0];
                REG_SAFE_WIDTH: r_cfg.safe_width <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_MIN_COUNT:  prdata = {16'd0, r_cfg.min_count};
            REG_SPAN_COUNT: prdata = {16'd0, r_cfg.span_count};
            REG_RAMP_STEP:  prdata = {16'd0, r_cfg.ramp_step};
            REG_SAFE_WIDTH: prdata = {16'd0, r_cfg.safe_width};
            default:        prdata = 32'd0;
        endcase
    end
endmodule

// ===== hw/rtl/spc_ctrl.sv =====
// controller state machine: accepts requests and walks the channels
module spc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  spc_pkg::t_dp_sts i_sts,
    output spc_pkg::t_dp_cmd o_cmd
);
    import spc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.go_walk) begin
                        n_state = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                if (i_sts.emit_here) begin
                    n_state = ST_EMIT;
                end else if (i_sts.done) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.next_idx = 1'b1;
                end
            end
            ST_EMIT: begin
                // wait here while the output register is still held
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_sts.done) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.next_idx = 1'b1;
                        n_state        = ST_CALC;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/spc_dp.sv =====
// datapath: channel widths, stop flag, ramp and compare arithmetic, output register
module spc_dp #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spc_pkg::t_cfg    i_cfg,
    input  spc_pkg::t_dp_cmd i_cmd,
    output spc_pkg::t_dp_sts o_sts,
    input  logic [2:0]       i_mode,
    input  logic [7:0]       i_channel,
    input  logic [15:0]      i_width,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_kind,
    output logic [1:0]       o_out_channel,
    output logic [15:0]      o_compare_count,
    output logic [15:0]      o_current_width,
    output logic             o_read_ok,
    output logic             o_last
);
    import spc_pkg::*;

    localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_CHANNELS - 1);

    logic [15:0] r_target  [NUM_CHANNELS];
    logic [15:0] r_present [NUM_CHANNELS];

    logic                    r_stop;
    logic [IW-1:0]           r_idx;
    logic [NUM_CHANNELS-1:0] r_emit;
    logic [NUM_CHANNELS-1:0] r_sel;
    logic                    r_wrp;
    logic                    r_tick;
    logic                    r_read;
    logic                    r_ok;
    logic [15:0]             r_w;
    logic [15:0]             r_res_width;
    logic [31:0]             r_prod;

    logic        r_out_valid;
    logic        r_kind;
    logic [1:0]  r_och;
    logic [15:0] r_cmp;
    logic [15:0] r_cur;
    logic        r_rok;
    logic        r_last;

    t_mode                   mode;
    logic                    ch_all;
    logic                    ch_ok;
    logic                    ch_valid;
    logic [15:0]             w_in;
    logic [NUM_CHANNELS-1:0] sel_in;
    logic [NUM_CHANNELS-1:0] n_emit;
    logic [NUM_CHANNELS-1:0] n_sel;
    logic [15:0]             n_w;
    logic [IW-1:0]           n_idx;
    logic                    n_stop;
    logic                    n_tick;
    logic                    n_read;
    logic                    go_walk;
    logic                    ramp_wr;

    logic [15:0]             cur;
    logic [15:0]             tgt;
    logic [16:0]             up_sum;
    logic [15:0]             dn_val;
    logic [15:0]             nxt;
    logic [15:0]             calc_w;
    logic [17:0]             cnt_sum;
    logic [15:0]             cnt_sat;
    logic [NUM_CHANNELS-1:0] later;
    logic                    last_res;

    assign mode     = t_mode'(i_mode);
    assign ch_all   = (i_channel == ALL_CH);
    assign ch_ok    = (i_channel < 8'(NUM_CHANNELS));
    assign ch_valid = ch_all || ch_ok;
    assign w_in     = sat_width(i_width);

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_sel
        assign sel_in[g] = ch_all || (i_channel == 8'(g));
    end

    // request decode at acceptance
    always_comb begin
        n_emit  = '0;
        n_sel   = '0;
        n_w     = w_in;
        n_idx   = '0;
        n_stop  = r_stop;
        n_tick  = 1'b0;
        n_read  = 1'b0;
        go_walk = 1'b0;
        ramp_wr = 1'b0;
        case (mode)
            MODE_SET_NOW: begin
                if (ch_valid) begin
                    go_walk = 1'b1;
                    n_sel   = sel_in;
                    n_emit  = r_stop ? '0 : sel_in;
                end
            end
            MODE_SET_RAMP: ramp_wr = ch_valid;
            MODE_STOP: begin
                go_walk = 1'b1;
                n_sel   = '1;
                n_emit  = r_stop ? '0 : '1;
                n_w     = sat_width(i_cfg.safe_width);
                n_stop  = 1'b1;
            end
            MODE_RELEASE: n_stop = 1'b0;
            MODE_TICK: begin
                go_walk = 1'b1;
                n_tick  = 1'b1;
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    n_emit[i] = !r_stop && (r_present[i] != r_target[i])
                                && (i_cfg.ramp_step != 16'd0);
                end
            end
            MODE_READ: begin
                go_walk = 1'b1;
                n_read  = 1'b1;
                if (ch_ok) begin
                    n_idx = i_channel[IW-1:0];
                end
            end
            default: ;
        endcase
    end

    // one ramp step on the channel under the walk pointer
    assign cur    = r_present[r_idx];
    assign tgt    = r_target[r_idx];
    assign up_sum = {1'b0, cur} + {1'b0, i_cfg.ramp_step};
    assign dn_val = (cur >= i_cfg.ramp_step) ? (cur - i_cfg.ramp_step) : 16'd0;

    always_comb begin
        if (cur < tgt) begin
            nxt = (up_sum > {1'b0, tgt}) ? tgt : up_sum[15:0];
        end else if (cur > tgt) begin
            nxt = (dn_val < tgt) ? tgt : dn_val;
        end else begin
            nxt = cur;
        end
    end

    always_comb begin
        if (r_read) begin
            calc_w = r_ok ? cur : 16'd0;
        end else if (r_tick) begin
            calc_w = nxt;
        end else begin
            calc_w = r_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop <= 1'b0;
        end else if (i_cmd.accept) begin
            r_stop <= n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx  <= n_idx;
            r_emit <= n_emit;
            r_sel  <= n_sel;
            r_wrp  <= !r_stop;
            r_tick <= n_tick;
            r_read <= n_read;
            r_ok   <= ch_ok;
            r_w    <= n_w;
        end else if (i_cmd.next_idx) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.calc) begin
            r_res_width <= calc_w;
            r_prod      <= {16'd0, calc_w} * {16'd0, i_cfg.span_count};
        end
    end

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
        logic here;
        assign here = (r_idx == IW'(g));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_target[g]  <= 16'd0;
                r_present[g] <= 16'd0;
            end else begin
                if (i_cmd.accept && ramp_wr && sel_in[g]) begin
                    r_target[g] <= w_in;
                end else if (i_cmd.calc && here && !r_tick && !r_read && r_sel[g]) begin
                    r_target[g] <= r_w;
                end
                if (i_cmd.calc && here) begin
                    if (r_tick) begin
                        r_present[g] <= nxt;
                    end else if (!r_read && r_sel[g] && r_wrp) begin
                        r_present[g] <= r_w;
                    end
                end
            end
        end

        assign later[g] = r_emit[g] && (IW'(g) > r_idx);
    end

    // compare count from the registered product
    assign cnt_sum  = {2'b00, i_cfg.min_count} + {1'b0, r_prod[31:15]};
    assign cnt_sat  = (cnt_sum > {2'b00, COUNT_MAX}) ? COUNT_MAX : cnt_sum[15:0];
    assign last_res = r_read || !(|later);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_kind <= r_read;
            r_och  <= 2'(r_idx);
            r_cmp  <= r_read ? 16'd0 : cnt_sat;
            r_cur  <= r_res_width;
            r_rok  <= r_read && r_ok;
            r_last <= last_res;
        end
    end

    assign o_sts.go_walk   = go_walk;
    assign o_sts.emit_here = r_read || r_emit[r_idx];
    assign o_sts.done      = r_read || (r_idx == LAST_IDX);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_out_channel   = r_och;
    assign o_compare_count = r_cmp;
    assign o_current_width = r_cur;
    assign o_read_ok       = r_rok;
    assign o_last          = r_last;
endmodule

// ===== hw/rtl/servo_pulse_ramp_controller.sv =====
// Servo pulse controller with slew limit, top level.
// Requests arrive on i_req (mode, channel, width); compare updates and read
// replies leave on o_res, the final result of each walk marked by last.
// Four config registers (min count, span count, ramp step, safe width) sit on
// the apb port at byte addresses 0, 4, 8 and 12; pready is tied high.
// Sequencing: a request is taken when the controller is idle. Set now on a valid
// channel, safety stop and tick then walk every channel, with a calc step for each
// channel and an emit step for each channel that emits an update; a read passes
// through the calc state and then the emit state after acceptance. Ramped set and
// release finish in the accept cycle. The ready signal of i_req stays low while a
// walk is in progress; the walk, through a single ramp and multiply unit, sets the
// rate.
// The last result sits in an output register, so the next request can be taken
// while it waits. If the receiver stalls, the walk halts on the next update.
// Reset clears all widths and the stop flag and restores register defaults.
module servo_pulse_ramp_controller #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    spc_req_if.sink                    i_req,
    spc_res_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [spc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import spc_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    assign pready = 1'b1;

    spc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    spc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    spc_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_mode          (i_req.mode),
        .i_channel       (i_req.channel),
        .i_width         (i_req.width),
        .o_out_valid     (o_res.valid),
        .i_out_ready     (o_res.ready),
        .o_kind          (o_res.kind),
        .o_out_channel   (o_res.out_channel),
        .o_compare_count (o_res.compare_count),
        .o_current_width (o_res.current_width),
        .o_read_ok       (o_res.read_ok),
        .o_last          (o_res.last)
    );
endmodule

// ===== hw/rtl/spc_checker.sv =====
// port-level checks on the result channel, bound to the top level
module spc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_kind,
    input logic [1:0]  i_out_channel,
    input logic [15:0] i_compare_count,
    input logic [15:0] i_current_width,
    input logic        i_read_ok,
    input logic        i_last
);
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid
        && $stable({i_kind, i_out_channel, i_compare_count, i_current_width,
                    i_read_ok, i_last}))
        else $error("result changed while stalled");

    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_kind |-> i_last)
        else $error("read reply not marked last");

    a_bad_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_kind && !i_read_ok |-> i_out_channel == 2'd0
        && i_current_width == 16'd0 && i_compare_count == 16'd0)
        else $error("failed read reply carries data");

    a_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_kind |-> !i_read_ok && i_current_width <= 16'h8000)
        else $error("compare update malformed");
endmodule

bind servo_pulse_ramp_controller spc_checker u_spc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_kind          (o_res.kind),
    .i_out_channel   (o_res.out_channel),
    .i_compare_count (o_res.compare_count),
    .i_current_width (o_res.current_width),
    .i_read_ok       (o_res.read_ok),
    .i_last          (o_res.last)
);
